// ===== hw/rtl/sf2d_pkg.sv =====
// ----------------------------------------------------------------------------
// sf2d_pkg
// Shared constants and controller/datapath interface types for the separable
// 2-D filter.
// ----------------------------------------------------------------------------
package sf2d_pkg;

    localparam int PIX_W     = 8;
    localparam int COEF_W    = 16;
    localparam int FRAC_W    = 15;
    localparam int DIM_W     = 11;
    localparam int RAD_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int TAP_W     = 4;   // signed tap offset, covers radii up to seven

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_RADIUS = 3;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF0  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF2  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COEF3  = 3'd6;

    localparam logic [DIM_W-1:0]  RST_WIDTH  = 11'd1024;
    localparam logic [DIM_W-1:0]  RST_HEIGHT = 11'd1024;
    localparam logic [RAD_W-1:0]  RST_RADIUS = 2'd1;
    localparam logic [COEF_W-1:0] RST_COEF0  = 16'd32768;

    typedef struct packed {
        logic                    take;    // input beat accepted
        logic                    cfg_wr;  // configuration beat accepted
        logic                    clr;     // clear accumulators
        logic                    mac_h;   // add one horizontal tap
        logic                    mac_v;   // fold the row sum into the column sum
        logic                    load;    // move the result to the output register
        logic signed [TAP_W-1:0] dh;
        logic signed [TAP_W-1:0] dv;
    } t_cmd;

    typedef struct packed {
        logic             emit;
        logic             out_free;
        logic [RAD_W-1:0] radius;
    } t_status;

endpackage

// ===== hw/rtl/sf2d_datapath.sv =====
// ----------------------------------------------------------------------------
// sf2d_datapath
// Line store, frame counters, tap multiply-accumulate and output register.
// ----------------------------------------------------------------------------
module sf2d_datapath #(
    parameter int MAX_WIDTH  = sf2d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sf2d_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = sf2d_pkg::DEF_MAX_RADIUS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_op,
    input  logic [sf2d_pkg::PIX_W-1:0]       i_pixel,
    input  logic [sf2d_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sf2d_pkg::COEF_W-1:0]      i_cfg_data,
    input  sf2d_pkg::t_cmd                   i_cmd,
    output sf2d_pkg::t_status                o_status,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [sf2d_pkg::PIX_W-1:0]       o_pixel,
    output logic                             o_eor,
    output logic                             o_eof
);
    import sf2d_pkg::*;

    localparam int RING  = 2 * MAX_RADIUS + 2;
    localparam int DEPTH = RING * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(RING);
    localparam int SSW   = SW + 2;
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int ACC_W = COEF_W + PIX_W + $clog2(2 * MAX_RADIUS + 1);

    logic [DIM_W-1:0]  r_cfg_w, r_cfg_h;
    logic [RAD_W-1:0]  r_cfg_r;
    logic [COEF_W-1:0] r_coef [4];

    logic [CW-1:0] r_in_col, r_out_col;
    logic [HW-1:0] r_in_row, r_out_row;
    logic [SW-1:0] r_in_slot, r_out_slot;
    logic [PW-1:0] r_pend;
    logic          r_emit;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] r_rd_data;
    logic [ACC_W-1:0] r_acc_h, r_acc_v;

    logic [PIX_W-1:0] r_out_pix;
    logic             r_out_valid, r_out_eor, r_out_eof;

    // Effective frame geometry.
    logic [CW-1:0]    w_eff;
    logic [HW-1:0]    h_eff;
    logic [RAD_W-1:0] r_eff;
    logic [PW-1:0]    delay;

    always_comb begin
        if (r_cfg_w == '0) w_eff = CW'(1);
        else if (32'(r_cfg_w) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
        else w_eff = CW'(r_cfg_w);
        if (r_cfg_h == '0) h_eff = HW'(1);
        else if (32'(r_cfg_h) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
        else h_eff = HW'(r_cfg_h);
        if (32'(r_cfg_r) > MAX_RADIUS) r_eff = RAD_W'(MAX_RADIUS);
        else r_eff = r_cfg_r;
        delay = PW'(r_eff) * PW'(w_eff) + PW'(r_eff);
    end

    // Read address of the current tap, with both coordinates clamped to the frame.
    logic signed [CW:0]    col_s;
    logic [CW-1:0]         cc;
    logic signed [HW:0]    row_s, rr_s, off_s;
    logic signed [SSW-1:0] slot_t;
    logic [SW-1:0]         rd_slot;
    logic [AW-1:0]         rd_addr, wr_addr;

    always_comb begin
        col_s = $signed({1'b0, r_out_col}) + (CW+1)'(i_cmd.dh);
        if (col_s < 0) cc = '0;
        else if (col_s > $signed({1'b0, w_eff - CW'(1)})) cc = w_eff - CW'(1);
        else cc = col_s[CW-1:0];

        row_s = $signed({1'b0, r_out_row}) + (HW+1)'(i_cmd.dv);
        if (row_s < 0) rr_s = '0;
        else if (row_s > $signed({1'b0, h_eff - HW'(1)})) rr_s = $signed({1'b0, h_eff - HW'(1)});
        else rr_s = row_s;
        off_s  = rr_s - $signed({1'b0, r_out_row});
        slot_t = $signed(SSW'(r_out_slot)) + SSW'(off_s);
        if (slot_t < 0) slot_t = slot_t + SSW'(RING);
        else if (slot_t >= SSW'(RING)) slot_t = slot_t - SSW'(RING);
        rd_slot = slot_t[SW-1:0];

        rd_addr = AW'(rd_slot) * AW'(MAX_WIDTH) + AW'(cc);
        wr_addr = AW'(r_in_slot) * AW'(MAX_WIDTH) + AW'(r_in_col);
    end

    // Item bookkeeping.
    logic          in_open, wr_en;
    logic [PW-1:0] pend_inc;

    assign in_open  = r_in_row < h_eff;
    assign wr_en    = i_cmd.take && !i_op && in_open;
    assign pend_inc = r_pend + PW'(1);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_pixel;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Tap weights and the floor-and-saturate stage.
    function automatic logic [1:0] tap_sel(input logic signed [TAP_W-1:0] d);
        logic signed [TAP_W-1:0] a;
        a = (d < 0) ? -d : d;
        return a[1:0];
    endfunction

    function automatic logic [PIX_W-1:0] floor_sat(input logic [ACC_W-1:0] acc);
        logic [ACC_W-1:0] v;
        v = acc >> FRAC_W;
        return (v > ACC_W'(255)) ? 8'hFF : v[PIX_W-1:0];
    endfunction

    logic [PIX_W-1:0] h_val;
    assign h_val = floor_sat(r_acc_h);

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_acc_h <= '0;
            r_acc_v <= '0;
        end else if (i_cmd.mac_h) begin
            r_acc_h <= r_acc_h + ACC_W'(r_coef[tap_sel(i_cmd.dh)] * r_rd_data);
        end else if (i_cmd.mac_v) begin
            r_acc_h <= '0;
            r_acc_v <= r_acc_v + ACC_W'(r_coef[tap_sel(i_cmd.dv)] * h_val);
        end
    end

    logic eor, eof, cfg_hit;
    assign eor     = (r_out_col + CW'(1)) >= w_eff;
    assign eof     = eor && ((r_out_row + HW'(1)) >= h_eff);
    assign cfg_hit = i_cmd.cfg_wr && (i_cfg_index <= REG_COEF3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= RST_WIDTH;
            r_cfg_h     <= RST_HEIGHT;
            r_cfg_r     <= RST_RADIUS;
            r_coef[0]   <= RST_COEF0;
            r_coef[1]   <= '0;
            r_coef[2]   <= '0;
            r_coef[3]   <= '0;
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_in_slot   <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_out_slot  <= '0;
            r_pend      <= '0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cfg_wr) begin
                unique case (i_cfg_index)
                    REG_WIDTH:  r_cfg_w   <= i_cfg_data[DIM_W-1:0];
                    REG_HEIGHT: r_cfg_h   <= i_cfg_data[DIM_W-1:0];
                    REG_RADIUS: r_cfg_r   <= i_cfg_data[RAD_W-1:0];
                    REG_COEF0:  r_coef[0] <= i_cfg_data;
                    REG_COEF1:  r_coef[1] <= i_cfg_data;
                    REG_COEF2:  r_coef[2] <= i_cfg_data;
                    REG_COEF3:  r_coef[3] <= i_cfg_data;
                    default: ;
                endcase
            end

            // End of frame or any register write starts a fresh frame.
            if ((i_cmd.load && eof) || cfg_hit) begin
                r_in_col   <= '0;
                r_in_row   <= '0;
                r_in_slot  <= '0;
                r_out_col  <= '0;
                r_out_row  <= '0;
                r_out_slot <= '0;
                r_pend     <= '0;
            end else if (i_cmd.take) begin
                if (wr_en) begin
                    r_pend <= pend_inc;
                    if ((r_in_col + CW'(1)) >= w_eff) begin
                        r_in_col <= '0;
                        r_in_row <= r_in_row + HW'(1);
                        r_in_slot <= (32'(r_in_slot) == RING - 1) ? '0 : r_in_slot + SW'(1);
                    end else begin
                        r_in_col <= r_in_col + CW'(1);
                    end
                end
            end else if (i_cmd.load) begin
                r_pend <= r_pend - PW'(1);
                if (eor) begin
                    r_out_col  <= '0;
                    r_out_row  <= r_out_row + HW'(1);
                    r_out_slot <= (32'(r_out_slot) == RING - 1) ? '0 : r_out_slot + SW'(1);
                end else begin
                    r_out_col <= r_out_col + CW'(1);
                end
            end

            if (i_cmd.take) begin
                if (wr_en) begin
                    r_emit <= pend_inc > delay;
                end else begin
                    r_emit <= !in_open && (r_out_row < h_eff);
                end
            end

            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_pix <= floor_sat(r_acc_v);
            r_out_eor <= eor;
            r_out_eof <= eof;
        end
    end

    assign o_status.emit     = r_emit;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.radius   = r_eff;
    assign o_out_valid       = r_out_valid;
    assign o_pixel           = r_out_pix;
    assign o_eor             = r_out_eor;
    assign o_eof             = r_out_eof;

endmodule

// ===== hw/rtl/sf2d_ctrl.sv =====
// ----------------------------------------------------------------------------
// sf2d_ctrl
// Sequencer that walks the kernel taps, columns inside rows, for one result.
// ----------------------------------------------------------------------------
module sf2d_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  sf2d_pkg::t_status i_status,
    output sf2d_pkg::t_cmd    o_cmd
);
    import sf2d_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_MAC  = 3'd3;
    localparam logic [2:0] S_HFIN = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]              r_state, n_state;
    logic signed [TAP_W-1:0] r_dh, n_dh, r_dv, n_dv;
    logic signed [TAP_W-1:0] rad;

    assign rad = $signed(TAP_W'(i_status.radius));

    always_comb begin
        n_state      = r_state;
        n_dh         = r_dh;
        n_dv         = r_dv;
        o_cfg_ready  = 1'b0;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        o_cmd.dh     = r_dh;
        o_cmd.dv     = r_dv;
        unique case (r_state)
            S_IDLE: begin
                o_cfg_ready   = 1'b1;
                o_in_ready    = !i_cfg_valid;
                o_cmd.cfg_wr  = i_cfg_valid;
                o_cmd.take    = i_in_valid && !i_cfg_valid;
                if (o_cmd.take) n_state = S_EVAL;
            end
            S_EVAL: begin
                if (i_status.emit) begin
                    o_cmd.clr = 1'b1;
                    n_dh      = -rad;
                    n_dv      = -rad;
                    n_state   = S_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RD: n_state = S_MAC;
            S_MAC: begin
                o_cmd.mac_h = 1'b1;
                if (r_dh == rad) begin
                    n_state = S_HFIN;
                end else begin
                    n_dh    = r_dh + TAP_W'(1);
                    n_state = S_RD;
                end
            end
            S_HFIN: begin
                o_cmd.mac_v = 1'b1;
                n_dh        = -rad;
                if (r_dv == rad) begin
                    n_state = S_DONE;
                end else begin
                    n_dv    = r_dv + TAP_W'(1);
                    n_state = S_RD;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dh    <= '0;
            r_dv    <= '0;
        end else begin
            r_state <= n_state;
            r_dh    <= n_dh;
            r_dv    <= n_dv;
        end
    end

endmodule

// ===== hw/rtl/separable_filter_2d.sv =====
// ----------------------------------------------------------------------------
// separable_filter_2d
// Separable 2-D filter with replicated borders on a raster pixel stream.
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata[7:0] pixel_in, tuser op (1 = drain tick)
//  m_axis    out        tdata[7:0] pixel_out, tlast end_of_row, tuser end_of_frame
//  cfg       in         index selects register, data holds its value
//
// A beat that yields a result reads and accumulates every tap through the single
// line store read port, one multiply-accumulate per tap, folds each row sum into
// the column sum and waits for a free output register. The output register lets
// the next beat be taken while a result waits. Reset clears the counters and
// loads the register defaults; the line store is not cleared.
// ----------------------------------------------------------------------------
module separable_filter_2d #(
    parameter int MAX_WIDTH  = sf2d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sf2d_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = sf2d_pkg::DEF_MAX_RADIUS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] pixel_in
    input  logic                           s_axis_tuser,   // [0] op
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,   // [7:0] pixel_out
    output logic                           m_axis_tlast,
    output logic                           m_axis_tuser,   // [0] end_of_frame
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sf2d_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sf2d_pkg::COEF_W-1:0]    i_cfg_data
);
    import sf2d_pkg::*;

    t_cmd    cmd;
    t_status status;

    sf2d_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sf2d_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (s_axis_tuser),
        .i_pixel     (s_axis_tdata),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_pixel     (m_axis_tdata),
        .o_eor       (m_axis_tlast),
        .o_eof       (m_axis_tuser)
    );

endmodule
